@@ rtl/hck_pkg.sv @@
// shared constants and types for the hsl color key mask block
package hck_pkg;

   localparam int COLOR_W       = 8;
   localparam int MASK_W        = 8;
   localparam int FRACTION_BITS = 12;
   localparam int FRAC_W        = FRACTION_BITS + 1;
   localparam int HUE_W         = 13;
   localparam int HUE_HW_W      = 12;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 13;

   localparam int HUE_FULL  = 5760;
   localparam int HUE_SIXTH = 960;

   // floor(2^32 / 255) for the lightness scaling
   localparam logic [24:0] L_RECIP = 25'd16843009;

   localparam logic [CSR_IDX_W-1:0] CSR_HUE_CENTRE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HUE_HALF_WIDTH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAT_LOWER      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAT_UPPER      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_LOWER    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_UPPER    = 3'd5;

   typedef enum logic [1:0] {
      MAX_RED,
      MAX_GREEN,
      MAX_BLUE
   } max_sel_type;

   typedef struct packed {
      logic [20:0]       rem_h;
      logic [HUE_W-1:0]  q_h;
      logic [7:0]        dv_h;
      logic [19:0]       rem_s;
      logic [FRAC_W-1:0] q_s;
      logic [7:0]        dv_s;
      logic [FRAC_W-1:0] l;
   } div_stage_type;

   typedef struct packed {
      logic [45:0] rem;
      logic [37:0] den;
      logic [7:0]  q;
   } mdiv_stage_type;

endpackage

@@ rtl/hck_stream_if.sv @@
// pixel request and mask response stream interfaces
interface hck_req_if;
   logic                        valid;
   logic                        ready;
   logic [hck_pkg::COLOR_W-1:0] red;
   logic [hck_pkg::COLOR_W-1:0] green;
   logic [hck_pkg::COLOR_W-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface hck_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [hck_pkg::MASK_W-1:0] mask_level;
   modport source (output valid, mask_level, input ready);
   modport sink (input valid, mask_level, output ready);
endinterface

@@ rtl/hsl_color_key_mask.sv @@
// hsl color keyer: rgb to hsl conversion, window tests and mask level, fully pipelined
// each pixel passes s1, s2, the hue and saturation dividers, m1 to m5 and the mask divider before its result is offered
// throughput: one pixel per cycle while the response is not stalled, set by the 28-stage register pipeline
// hue and saturation use 13-stage restoring dividers, the mask level an 8-stage one
// stages stall in place and fill bubbles, so input is taken while a result waits as long as a stage ahead is empty
// reset clears all stage valid bits and loads the register defaults
module hsl_color_key_mask (
   input  logic                                clock,
   input  logic                                reset,
   hck_req_if.sink                             req_ch,
   hck_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [hck_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hck_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int DIV_N   = hck_pkg::HUE_W;
   localparam int MDIV_N  = hck_pkg::MASK_W;
   localparam int ST_S1   = 0;
   localparam int ST_S2   = 1;
   localparam int ST_DIV  = 2;
   localparam int ST_M1   = ST_DIV + DIV_N;
   localparam int ST_M2   = ST_M1 + 1;
   localparam int ST_M3   = ST_M2 + 1;
   localparam int ST_M4   = ST_M3 + 1;
   localparam int ST_M5   = ST_M4 + 1;
   localparam int ST_MDIV = ST_M5 + 1;
   localparam int NSTG    = ST_MDIV + MDIV_N;

   // configuration registers
   logic [hck_pkg::HUE_W-1:0]    hc_ff;
   logic [hck_pkg::HUE_HW_W-1:0] hw_ff;
   logic [hck_pkg::FRAC_W-1:0]   sl_ff, su_ff, ll_ff, lu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff <= 13'd0;
         hw_ff <= 12'd480;
         sl_ff <= 13'd0;
         su_ff <= 13'd4096;
         ll_ff <= 13'd0;
         lu_ff <= 13'd4096;
      end else if (csr_wr_en) begin
         case (csr_index)
            hck_pkg::CSR_HUE_CENTRE:     hc_ff <= csr_wdata;
            hck_pkg::CSR_HUE_HALF_WIDTH: hw_ff <= csr_wdata[11:0];
            hck_pkg::CSR_SAT_LOWER:      sl_ff <= csr_wdata;
            hck_pkg::CSR_SAT_UPPER:      su_ff <= csr_wdata;
            hck_pkg::CSR_LIGHT_LOWER:    ll_ff <= csr_wdata;
            hck_pkg::CSR_LIGHT_UPPER:    lu_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // valid bits and stage enables
   logic [NSTG-1:0] v_ff, v_in, en;

   always_comb begin
      en[NSTG-1] = !v_ff[NSTG-1] || rsp_ch.ready;
      for (int k = NSTG - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      for (int k = 0; k < NSTG; k++) begin
         if (en[k]) begin
            v_in[k] = (k == 0) ? req_ch.valid : v_ff[(k == 0) ? 0 : k - 1];
         end else begin
            v_in[k] = v_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_ch.ready = en[ST_S1];

   // stage s1: max, min, difference
   logic [7:0]           s1_d_ff, s1_d_in;
   logic [8:0]           s1_sum_ff, s1_sum_in;
   hck_pkg::max_sel_type s1_sel_ff, s1_sel_in;
   logic signed [8:0]    s1_diff_ff, s1_diff_in;

   always_comb begin
      logic [7:0] mx, mn;
      logic [7:0] r, g, b;
      r = req_ch.red;
      g = req_ch.green;
      b = req_ch.blue;
      if (r >= g && r >= b) begin
         s1_sel_in  = hck_pkg::MAX_RED;
         mx         = r;
         s1_diff_in = $signed({1'b0, g}) - $signed({1'b0, b});
      end else if (g >= b) begin
         s1_sel_in  = hck_pkg::MAX_GREEN;
         mx         = g;
         s1_diff_in = $signed({1'b0, b}) - $signed({1'b0, r});
      end else begin
         s1_sel_in  = hck_pkg::MAX_BLUE;
         mx         = b;
         s1_diff_in = $signed({1'b0, r}) - $signed({1'b0, g});
      end
      mn = r;
      if (g < mn) begin
         mn = g;
      end
      if (b < mn) begin
         mn = b;
      end
      s1_d_in   = mx - mn;
      s1_sum_in = 9'(mx) + 9'(mn);
   end

   always_ff @(posedge clock) begin
      if (en[ST_S1]) begin
         s1_d_ff    <= s1_d_in;
         s1_sum_ff  <= s1_sum_in;
         s1_sel_ff  <= s1_sel_in;
         s1_diff_ff <= s1_diff_in;
      end
   end

   // stage s2: hue numerator, saturation divisor, lightness estimate
   logic [20:0]                s2_num_ff, s2_num_in;
   logic [7:0]                 s2_d_ff;
   logic [7:0]                 s2_den_ff, s2_den_in;
   logic [8:0]                 s2_sum_ff;
   logic [hck_pkg::FRAC_W-1:0] s2_lq_ff, s2_lq_in;

   always_comb begin
      logic [12:0]        base;
      logic [20:0]        base_prod;
      logic signed [22:0] off;
      logic signed [22:0] num;
      logic [19:0]        lx;
      logic [44:0]        lprod;
      unique case (s1_sel_ff)
         hck_pkg::MAX_RED:   base = s1_diff_ff[8] ? 13'(hck_pkg::HUE_FULL) : 13'd0;
         hck_pkg::MAX_GREEN: base = 13'(2 * hck_pkg::HUE_SIXTH);
         default:            base = 13'(4 * hck_pkg::HUE_SIXTH);
      endcase
      base_prod = 21'(base) * 21'(s1_d_ff);
      off       = 23'(s1_diff_ff) * 23'sd960;
      num       = $signed({2'b00, base_prod}) + off;
      s2_num_in = num[20:0];
      if (s1_sum_ff > 9'd255) begin
         s2_den_in = 8'(9'd510 - s1_sum_ff);
      end else begin
         s2_den_in = s1_sum_ff[7:0];
      end
      lx       = {s1_sum_ff, 11'b0};
      lprod    = 45'(lx) * 45'(hck_pkg::L_RECIP);
      s2_lq_in = lprod[44:32];
   end

   always_ff @(posedge clock) begin
      if (en[ST_S2]) begin
         s2_num_ff <= s2_num_in;
         s2_d_ff   <= s1_d_ff;
         s2_den_ff <= s2_den_in;
         s2_sum_ff <= s1_sum_ff;
         s2_lq_ff  <= s2_lq_in;
      end
   end

   // hue and saturation dividers, one quotient bit per stage
   hck_pkg::div_stage_type div_ff [DIV_N];
   hck_pkg::div_stage_type div_in [DIV_N];
   hck_pkg::div_stage_type div_src;

   always_comb begin
      logic [20:0] lx;
      logic [20:0] r;
      lx = {1'b0, s2_sum_ff, 11'b0};
      r  = lx - (21'({s2_lq_ff, 8'b0}) - 21'(s2_lq_ff));
      div_src.rem_h = s2_num_ff;
      div_src.q_h   = '0;
      div_src.dv_h  = s2_d_ff;
      div_src.rem_s = {s2_d_ff, 12'b0};
      div_src.q_s   = '0;
      div_src.dv_s  = s2_den_ff;
      div_src.l     = (r >= 21'd255) ? s2_lq_ff + 13'd1 : s2_lq_ff;
   end

   always_comb begin
      hck_pkg::div_stage_type src;
      logic [20:0]            sh_h;
      logic [19:0]            sh_s;
      for (int k = 0; k < DIV_N; k++) begin
         src  = (k == 0) ? div_src : div_ff[(k == 0) ? 0 : k - 1];
         sh_h = 21'(src.dv_h) << (DIV_N - 1 - k);
         sh_s = 20'(src.dv_s) << (DIV_N - 1 - k);
         div_in[k] = src;
         if (src.rem_h >= sh_h) begin
            div_in[k].rem_h = src.rem_h - sh_h;
            div_in[k].q_h[DIV_N-1-k] = 1'b1;
         end
         if (src.rem_s >= sh_s) begin
            div_in[k].rem_s = src.rem_s - sh_s;
            div_in[k].q_s[DIV_N-1-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_N; k++) begin
         if (en[ST_DIV+k]) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // stage m1: window tests and distances
   logic        m1_match_ff, m1_match_in;
   logic [13:0] m1_d1_ff, m1_d1_in;
   logic [14:0] m1_offs_ff, m1_offs_in;
   logic [14:0] m1_offl_ff, m1_offl_in;

   always_comb begin
      logic [hck_pkg::HUE_W-1:0]  h;
      logic [hck_pkg::FRAC_W-1:0] s, l;
      logic signed [14:0]         hc_s, hw_s, h_s, hmin, hmax, dh;
      logic signed [15:0]         ts, tl;
      logic                       hue_ok, sat_ok, light_ok;
      h = (div_ff[DIV_N-1].dv_h == 8'd0) ? '0 : div_ff[DIV_N-1].q_h;
      s = (div_ff[DIV_N-1].dv_h == 8'd0) ? '0 : div_ff[DIV_N-1].q_s;
      l = div_ff[DIV_N-1].l;
      hc_s = $signed(15'(hc_ff));
      hw_s = $signed(15'(hw_ff));
      h_s  = $signed(15'(h));
      hmin = hc_s - hw_s;
      hmax = hc_s + hw_s;
      hue_ok = (h_s >= hmin && h_s <= hmax)
            || (hmin < 0 && h_s >= hmin + 15'sd5760)
            || (hmax > 15'sd5760 && h_s <= hmax - 15'sd5760);
      sat_ok   = (s >= sl_ff) && (s <= su_ff);
      light_ok = (l >= ll_ff) && (l <= lu_ff);
      m1_match_in = hue_ok && sat_ok && light_ok;
      dh = h_s - hc_s;
      m1_d1_in = (dh < 0) ? 14'(-dh) : 14'(dh);
      ts = $signed({2'b00, s, 1'b0}) - $signed({3'b000, sl_ff}) - $signed({3'b000, su_ff});
      tl = $signed({2'b00, l, 1'b0}) - $signed({3'b000, ll_ff}) - $signed({3'b000, lu_ff});
      m1_offs_in = (ts < 0) ? 15'(-ts) : 15'(ts);
      m1_offl_in = (tl < 0) ? 15'(-tl) : 15'(tl);
   end

   always_ff @(posedge clock) begin
      if (en[ST_M1]) begin
         m1_match_ff <= m1_match_in;
         m1_d1_ff    <= m1_d1_in;
         m1_offs_ff  <= m1_offs_in;
         m1_offl_ff  <= m1_offl_in;
      end
   end

   // stage m2: falloff numerators and denominators
   logic [11:0] m2_nh_ff, m2_nh_in, m2_dh_ff, m2_dh_in;
   logic [12:0] m2_ns_ff, m2_ns_in, m2_ds_ff, m2_ds_in;
   logic [12:0] m2_nl_ff, m2_nl_in, m2_dl_ff, m2_dl_in;

   always_comb begin
      logic signed [14:0] d1, d2, hdist, hn, w_s;
      logic [12:0]        span_s, span_l;
      logic signed [15:0] ns_t, nl_t;
      logic [11:0]        nh;
      logic [12:0]        ns, nl;
      d1    = $signed({1'b0, m1_d1_ff});
      d2    = 15'sd5760 - d1;
      hdist = (d1 < d2) ? d1 : d2;
      w_s   = $signed(15'(hw_ff));
      hn    = w_s - hdist;
      if (hn < 0) begin
         nh = '0;
      end else if (hn > w_s) begin
         nh = hw_ff;
      end else begin
         nh = hn[11:0];
      end
      span_s = su_ff - sl_ff;
      span_l = lu_ff - ll_ff;
      ns_t = $signed({3'b000, span_s}) - $signed({1'b0, m1_offs_ff});
      nl_t = $signed({3'b000, span_l}) - $signed({1'b0, m1_offl_ff});
      ns = (ns_t < 0) ? '0 : ns_t[12:0];
      nl = (nl_t < 0) ? '0 : nl_t[12:0];
      if (!m1_match_ff) begin
         m2_nh_in = '0;
         m2_dh_in = 12'd1;
         m2_ns_in = '0;
         m2_ds_in = 13'd1;
         m2_nl_in = '0;
         m2_dl_in = 13'd1;
      end else begin
         m2_nh_in = (hw_ff == '0) ? 12'd1 : nh;
         m2_dh_in = (hw_ff == '0) ? 12'd1 : hw_ff;
         m2_ns_in = (span_s == '0) ? 13'd1 : ns;
         m2_ds_in = (span_s == '0) ? 13'd1 : span_s;
         m2_nl_in = (span_l == '0) ? 13'd1 : nl;
         m2_dl_in = (span_l == '0) ? 13'd1 : span_l;
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_M2]) begin
         m2_nh_ff <= m2_nh_in;
         m2_dh_ff <= m2_dh_in;
         m2_ns_ff <= m2_ns_in;
         m2_ds_ff <= m2_ds_in;
         m2_nl_ff <= m2_nl_in;
         m2_dl_ff <= m2_dl_in;
      end
   end

   // stages m3 to m5: products of the three factors
   logic [24:0] m3_pn_ff, m3_pd_ff;
   logic [12:0] m3_nl_ff, m3_dl_ff;
   logic [37:0] m4_num_ff, m4_den_ff;
   logic [45:0] m5_num_ff;
   logic [37:0] m5_den_ff;

   always_ff @(posedge clock) begin
      if (en[ST_M3]) begin
         m3_pn_ff <= 25'(m2_nh_ff) * 25'(m2_ns_ff);
         m3_pd_ff <= 25'(m2_dh_ff) * 25'(m2_ds_ff);
         m3_nl_ff <= m2_nl_ff;
         m3_dl_ff <= m2_dl_ff;
      end
      if (en[ST_M4]) begin
         m4_num_ff <= 38'(m3_pn_ff) * 38'(m3_nl_ff);
         m4_den_ff <= 38'(m3_pd_ff) * 38'(m3_dl_ff);
      end
      if (en[ST_M5]) begin
         m5_num_ff <= {m4_num_ff, 8'b0} - 46'(m4_num_ff);
         m5_den_ff <= m4_den_ff;
      end
   end

   // mask level divider, one quotient bit per stage
   hck_pkg::mdiv_stage_type mdiv_ff [MDIV_N];
   hck_pkg::mdiv_stage_type mdiv_in [MDIV_N];

   always_comb begin
      hck_pkg::mdiv_stage_type src;
      logic [45:0]             sh;
      for (int j = 0; j < MDIV_N; j++) begin
         if (j == 0) begin
            src.rem = m5_num_ff;
            src.den = m5_den_ff;
            src.q   = '0;
         end else begin
            src = mdiv_ff[(j == 0) ? 0 : j - 1];
         end
         sh = 46'(src.den) << (MDIV_N - 1 - j);
         mdiv_in[j] = src;
         if (src.rem >= sh) begin
            mdiv_in[j].rem = src.rem - sh;
            mdiv_in[j].q[MDIV_N-1-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < MDIV_N; j++) begin
         if (en[ST_MDIV+j]) begin
            mdiv_ff[j] <= mdiv_in[j];
         end
      end
   end

   assign rsp_ch.valid      = v_ff[NSTG-1];
   assign rsp_ch.mask_level = mdiv_ff[MDIV_N-1].q;

   // mask product denominator is never zero
   assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_M5] |-> m5_den_ff != '0)
      else $error("mask denominator is zero");

   // mask numerator bounded by 255 times the denominator
   assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_M5] |-> m5_num_ff <= ({m5_den_ff, 8'b0} - 46'(m5_den_ff)))
      else $error("mask ratio exceeds 255");

   // hue quotient stays below a full turn
   assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_M1-1] && div_ff[DIV_N-1].dv_h != 8'd0
      |-> div_ff[DIV_N-1].q_h < 13'd5760)
      else $error("hue out of range");

   // lightness after correction stays within one
   assert property (@(posedge clock) disable iff (reset)
      v_ff[ST_DIV] |-> div_ff[0].l <= 13'd4096)
      else $error("lightness out of range");

endmodule
